### rtl/mrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Magnetometer reliability scorer package
// Register indexes, reset values, score weights and the ring entry layout.
// ----------------------------------------------------------------------------
package mrs_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CAL_WINDOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VAR_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAG_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAG_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_W   = 3'd4;

  // Register reset values.
  localparam logic [4:0]  CAL_WINDOW_RST = 5'd16;
  localparam logic [31:0] VAR_LIMIT_RST  = 32'd1600;
  localparam logic [15:0] MAG_LOW_RST    = 16'd320;
  localparam logic [15:0] MAG_HIGH_RST   = 16'd1120;
  localparam logic [15:0] SMOOTH_W_RST   = 16'd58982;

  // State reset values.
  localparam logic [15:0] EXP_MAG_RST = 16'd800;
  localparam logic [15:0] SMOOTH_RST  = 16'd32768;

  // Score arithmetic, Q0.16.
  localparam logic [16:0] ONE_Q16    = 17'h10000;
  localparam logic [15:0] W_DEV      = 16'd19661;
  localparam logic [15:0] W_VAR      = 16'd32768;
  localparam logic [15:0] W_RNG      = 16'd13107;
  localparam logic [15:0] ROUND_HALF = 16'd32768;
  localparam int          MIN_FILL   = 3;
  localparam int          FRAC_STEPS = 16;

  // One ring entry: the raw sample and its magnitude.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [15:0]        mag;
  } ring_entry_t;

  // Square of one signed axis value; at most 2^30, so 31 bits.
  function automatic logic [30:0] sq16(input logic signed [15:0] a);
    logic signed [31:0] p;
    p = a * a;
    return p[30:0];
  endfunction

endpackage
`default_nettype wire

### rtl/mrs_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one magnetometer sample or a clear action.
// ----------------------------------------------------------------------------
interface mrs_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [15:0] mag_x;
  logic signed [15:0] mag_y;
  logic signed [15:0] mag_z;

  modport source (output valid, action, mag_x, mag_y, mag_z, input ready);
  modport sink   (input valid, action, mag_x, mag_y, mag_z, output ready);
endinterface
`default_nettype wire

### rtl/mrs_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one reliability result.
// ----------------------------------------------------------------------------
interface mrs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] reliability;
  logic        calibrated;
  logic [4:0]  history_fill;
  logic [15:0] expected_level;

  modport source (output valid, reliability, calibrated, history_fill, expected_level,
                  input ready);
  modport sink   (input valid, reliability, calibrated, history_fill, expected_level,
                  output ready);
endinterface
`default_nettype wire

### rtl/mrs_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer square root
// Digit-by-digit floor square root of a 32-bit value, one digit per cycle.
// ----------------------------------------------------------------------------
module mrs_isqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] value,
  output logic             done,
  output logic [15:0]      root
);

  logic        busy_r;
  logic        done_r;
  logic [31:0] v_r;
  logic [31:0] res_r;
  logic [31:0] bit_r;
  logic [31:0] trial;
  logic        take;
  logic [31:0] v_nxt;
  logic [31:0] res_nxt;

  // One digit of the root per cycle.
  always_comb begin
    trial   = res_r + bit_r;
    take    = (v_r >= trial);
    v_nxt   = take ? (v_r - trial) : v_r;
    res_nxt = take ? ((res_r >> 1) + bit_r) : (res_r >> 1);
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= value;
      res_r <= '0;
      bit_r <= 32'h4000_0000;
    end else if (busy_r) begin
      v_r   <= v_nxt;
      res_r <= res_nxt;
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[15:0];

endmodule
`default_nettype wire

### rtl/mrs_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Restoring divider
// Shared long divider, one quotient bit per cycle. The remainder may start
// non-zero (below the divisor) for fractional quotients.
// ----------------------------------------------------------------------------
module mrs_div #(
  parameter int DVW = 40,
  parameter int QW  = 21,
  parameter int SW  = 5
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [DVW-1:0] rem_init,
  input  wire logic [QW-1:0]  src,
  input  wire logic [DVW-1:0] divisor,
  input  wire logic [SW-1:0]  steps,
  output logic                done,
  output logic [QW-1:0]       quo
);

  logic           busy_r;
  logic           done_r;
  logic [SW-1:0]  cnt_r;
  logic [DVW-1:0] rem_r;
  logic [DVW-1:0] div_r;
  logic [QW-1:0]  src_r;
  logic [QW-1:0]  quo_r;
  logic [DVW:0]   rem2;
  logic           ge;
  logic [DVW:0]   diff;
  logic [DVW-1:0] rem_nxt;

  // One trial subtraction per cycle.
  always_comb begin
    rem2    = {rem_r, src_r[QW-1]};
    ge      = (rem2 >= {1'b0, div_r});
    diff    = rem2 - {1'b0, div_r};
    rem_nxt = ge ? diff[DVW-1:0] : rem2[DVW-1:0];
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - SW'(1);
        if (cnt_r == SW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      div_r <= divisor;
      src_r <= src;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      src_r <= {src_r[QW-2:0], 1'b0};
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

### rtl/magnetometer_reliability_scorer.sv
`timescale 1ns / 1ps
`default_nettype none
// One item is processed at a time; the ring walk goes through the single memory read port
// and the divider is shared and serial. A new item is taken while a result waits.
// Reset (synchronous, active low) empties the ring and restores register defaults.
// ----------------------------------------------------------------------------
// Magnetometer reliability scorer
// Ring of recent samples in a synchronous memory; once three samples are held,
// each sample is walked for variance and calibration, scored, and smoothed.
// ----------------------------------------------------------------------------
module magnetometer_reliability_scorer #(
  parameter int RING_DEPTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  mrs_in_if.sink                               in_ch,
  mrs_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [mrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mrs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mrs_pkg::*;

  localparam int PW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW    = $clog2(RING_DEPTH + 1);
  localparam int CMPW  = (CW > 5) ? CW : 5;
  localparam int SXW   = 16 + CW;
  localparam int SXXW  = 31 + CW;
  localparam int MSW   = 16 + CW;
  localparam int AW    = CW + SXXW;
  localparam int BW    = 2 * SXW;
  localparam int NUMW  = AW + 2;
  localparam int DENW  = 2 * CW + 32;
  localparam int QW    = MSW;
  localparam int SW    = $clog2(QW + 1);

  // Sequencer states.
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SQ   = 5'd1;
  localparam logic [4:0] S_ROOT = 5'd2;
  localparam logic [4:0] S_WR   = 5'd3;
  localparam logic [4:0] S_WALK = 5'd4;
  localparam logic [4:0] S_CAL  = 5'd5;
  localparam logic [4:0] S_CALW = 5'd6;
  localparam logic [4:0] S_DEV  = 5'd7;
  localparam logic [4:0] S_DEVW = 5'd8;
  localparam logic [4:0] S_VAR1 = 5'd9;
  localparam logic [4:0] S_VAR2 = 5'd10;
  localparam logic [4:0] S_VAR3 = 5'd11;
  localparam logic [4:0] S_VARW = 5'd12;
  localparam logic [4:0] S_MIX  = 5'd13;
  localparam logic [4:0] S_SMO1 = 5'd14;
  localparam logic [4:0] S_SMO2 = 5'd15;
  localparam logic [4:0] S_OUT  = 5'd16;

  // Configuration registers.
  logic [4:0]  cal_window_r;
  logic [31:0] var_limit_r;
  logic [15:0] mag_low_r;
  logic [15:0] mag_high_r;
  logic [15:0] smooth_w_r;

  // Control state.
  logic [4:0]    state_r, state_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          cal_done_r, cal_done_nxt;
  logic [15:0]   exp_mag_r, exp_mag_nxt;
  logic [15:0]   smooth_r, smooth_nxt;
  logic          calib_r, calib_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic          sq_vld_r;
  logic          out_valid_r, out_valid_nxt;

  // Item payload.
  logic               act_r;
  logic signed [15:0] mx_r, my_r, mz_r;
  logic [15:0]        m_r;
  logic [16:0]        ms_r, vs_r, r_r;
  logic [15:0]        rel_r;

  // Walk pipeline and sums.
  ring_entry_t         mem [RING_DEPTH];
  ring_entry_t         mem_q_r;
  logic signed [15:0]  px_r, py_r, pz_r;
  logic [15:0]         pmag_r;
  logic [30:0]         sqx_r, sqy_r, sqz_r;
  logic signed [SXW-1:0] sx_r [3];
  logic [SXXW-1:0]     sxx_r [3];
  logic [MSW-1:0]      msum_r;

  // Variance terms.
  logic [AW-1:0]   a_r [3];
  logic [BW-1:0]   b_r [3];
  logic [2*CW-1:0] nn_r;
  logic [NUMW-1:0] num_r;
  logic [DENW-1:0] den_r;
  logic [31:0]     p1_r;
  logic [33:0]     p2_r;

  // Shared units.
  logic            sqrt_start, sqrt_done;
  logic [15:0]     sqrt_root;
  logic [31:0]     sq_sum;
  logic            div_start, div_done;
  logic [DENW-1:0] div_rem_init, div_divisor;
  logic [QW-1:0]   div_src, div_quo;
  logic [SW-1:0]   div_steps;

  // Combinational helpers.
  logic            in_xfer, out_xfer;
  logic            mem_we, mem_re;
  logic [CW-1:0]   fill_inc;
  logic            calib_now;
  logic [15:0]     dev;
  logic [16:0]     dev2;
  logic            dev_zero;
  logic signed [BW-1:0] bsq [3];
  logic [NUMW-1:0] num_sum;
  logic [33:0]     mix_sum;
  logic [33:0]     smo_sum;
  logic [17:0]     smo_q;
  logic            in_range;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_valid_r && out_ch.ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_window_r <= CAL_WINDOW_RST;
      var_limit_r  <= VAR_LIMIT_RST;
      mag_low_r    <= MAG_LOW_RST;
      mag_high_r   <= MAG_HIGH_RST;
      smooth_w_r   <= SMOOTH_W_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAL_WINDOW: cal_window_r <= cfg_data[4:0];
        REG_VAR_LIMIT:  var_limit_r  <= cfg_data[31:0];
        REG_MAG_LOW:    mag_low_r    <= cfg_data[15:0];
        REG_MAG_HIGH:   mag_high_r   <= cfg_data[15:0];
        REG_SMOOTH_W:   smooth_w_r   <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Magnitude of the incoming sample.
  assign sq_sum = 32'(sq16(mx_r)) + 32'(sq16(my_r)) + 32'(sq16(mz_r));

  mrs_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .value (sq_sum),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  mrs_div #(
    .DVW (DENW),
    .QW  (QW),
    .SW  (SW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem_init),
    .src      (div_src),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quo      (div_quo)
  );

  // Score arithmetic helpers.
  always_comb begin
    fill_inc  = (fill_r < CW'(RING_DEPTH)) ? (fill_r + CW'(1)) : fill_r;
    calib_now = !cal_done_r && (CMPW'(fill_inc) >= CMPW'(cal_window_r));
    dev       = (m_r > exp_mag_r) ? (m_r - exp_mag_r) : (exp_mag_r - m_r);
    dev2      = {dev, 1'b0};
    dev_zero  = (exp_mag_r == 16'd0) || (dev2 >= {1'b0, exp_mag_r});
    for (int k = 0; k < 3; k++) begin
      bsq[k] = sx_r[k] * sx_r[k];
    end
    num_sum = '0;
    for (int k = 0; k < 3; k++) begin
      num_sum = num_sum + NUMW'(a_r[k]) - NUMW'(b_r[k]);
    end
    in_range = (m_r >= mag_low_r) && (m_r <= mag_high_r);
    mix_sum  = 34'(W_DEV) * 34'(ms_r) + 34'(W_VAR) * 34'(vs_r) + 34'(W_RNG) * 34'(r_r)
             + 34'(ROUND_HALF);
    smo_sum  = 34'(p1_r) + p2_r + 34'(ROUND_HALF);
    smo_q    = smo_sum[33:16];
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    cal_done_nxt  = cal_done_r;
    exp_mag_nxt   = exp_mag_r;
    smooth_nxt    = smooth_r;
    calib_nxt     = calib_r;
    iss_nxt       = iss_r;
    rd_vld_nxt    = 1'b0;
    out_valid_nxt = out_xfer ? 1'b0 : out_valid_r;
    sqrt_start    = 1'b0;
    div_start     = 1'b0;
    div_rem_init  = '0;
    div_src       = '0;
    div_divisor   = '0;
    div_steps     = SW'(FRAC_STEPS);
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        if (act_r) begin
          fill_nxt     = '0;
          wp_nxt       = '0;
          cal_done_nxt = 1'b0;
          state_nxt    = S_OUT;
        end else begin
          sqrt_start = 1'b1;
          state_nxt  = S_ROOT;
        end
      end
      S_ROOT: begin
        if (sqrt_done) begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        mem_we    = 1'b1;
        wp_nxt    = (wp_r == PW'(RING_DEPTH - 1)) ? '0 : (wp_r + PW'(1));
        fill_nxt  = fill_inc;
        calib_nxt = calib_now;
        iss_nxt   = '0;
        state_nxt = (fill_inc < CW'(MIN_FILL)) ? S_OUT : S_WALK;
      end
      S_WALK: begin
        // The sample write finished before the walk starts, so no entry is
        // read while it is being written.
        if (iss_r < fill_r) begin
          mem_re     = 1'b1;
          rd_vld_nxt = 1'b1;
          iss_nxt    = iss_r + CW'(1);
        end else if (!rd_vld_r && !sq_vld_r) begin
          state_nxt = S_CAL;
        end
      end
      S_CAL: begin
        if (calib_r) begin
          div_start   = 1'b1;
          div_src     = msum_r;
          div_divisor = DENW'(fill_r);
          div_steps   = SW'(QW);
          state_nxt   = S_CALW;
        end else begin
          state_nxt = S_DEV;
        end
      end
      S_CALW: begin
        if (div_done) begin
          exp_mag_nxt  = div_quo[15:0];
          cal_done_nxt = 1'b1;
          state_nxt    = S_DEV;
        end
      end
      S_DEV: begin
        if (dev_zero) begin
          state_nxt = S_VAR1;
        end else begin
          div_start    = 1'b1;
          div_rem_init = DENW'(dev2);
          div_divisor  = DENW'(exp_mag_r);
          state_nxt    = S_DEVW;
        end
      end
      S_DEVW: begin
        if (div_done) begin
          state_nxt = S_VAR1;
        end
      end
      S_VAR1: begin
        state_nxt = S_VAR2;
      end
      S_VAR2: begin
        state_nxt = S_VAR3;
      end
      S_VAR3: begin
        if (num_r >= NUMW'(den_r)) begin
          state_nxt = S_MIX;
        end else begin
          div_start    = 1'b1;
          div_rem_init = num_r[DENW-1:0];
          div_divisor  = den_r;
          state_nxt    = S_VARW;
        end
      end
      S_VARW: begin
        if (div_done) begin
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        state_nxt = S_SMO1;
      end
      S_SMO1: begin
        state_nxt = S_SMO2;
      end
      S_SMO2: begin
        smooth_nxt = (smo_q > 18'd65535) ? 16'hFFFF : smo_q[15:0];
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      cal_done_r  <= 1'b0;
      exp_mag_r   <= EXP_MAG_RST;
      smooth_r    <= SMOOTH_RST;
      calib_r     <= 1'b0;
      iss_r       <= '0;
      rd_vld_r    <= 1'b0;
      sq_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      cal_done_r  <= cal_done_nxt;
      exp_mag_r   <= exp_mag_nxt;
      smooth_r    <= smooth_nxt;
      calib_r     <= calib_nxt;
      iss_r       <= iss_nxt;
      rd_vld_r    <= rd_vld_nxt;
      sq_vld_r    <= rd_vld_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Sample ring memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= '{x: mx_r, y: my_r, z: mz_r, mag: m_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q_r <= mem[iss_r[PW-1:0]];
    end
  end

  // Walk pipeline: squares, then running sums.
  always_ff @(posedge clk) begin
    px_r   <= mem_q_r.x;
    py_r   <= mem_q_r.y;
    pz_r   <= mem_q_r.z;
    pmag_r <= mem_q_r.mag;
    sqx_r  <= sq16(mem_q_r.x);
    sqy_r  <= sq16(mem_q_r.y);
    sqz_r  <= sq16(mem_q_r.z);
    if (state_r == S_WR) begin
      for (int k = 0; k < 3; k++) begin
        sx_r[k]  <= '0;
        sxx_r[k] <= '0;
      end
      msum_r <= '0;
    end else if (sq_vld_r) begin
      sx_r[0]  <= sx_r[0] + SXW'(px_r);
      sx_r[1]  <= sx_r[1] + SXW'(py_r);
      sx_r[2]  <= sx_r[2] + SXW'(pz_r);
      sxx_r[0] <= sxx_r[0] + SXXW'(sqx_r);
      sxx_r[1] <= sxx_r[1] + SXXW'(sqy_r);
      sxx_r[2] <= sxx_r[2] + SXXW'(sqz_r);
      msum_r   <= msum_r + MSW'(pmag_r);
    end
  end

  // Item payload and score datapath.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_r <= in_ch.action;
      mx_r  <= in_ch.mag_x;
      my_r  <= in_ch.mag_y;
      mz_r  <= in_ch.mag_z;
    end
    if (sqrt_done) begin
      m_r <= sqrt_root;
    end
    case (state_r)
      S_SQ:   rel_r <= '0;
      S_WR:   rel_r <= '0;
      S_DEV:  ms_r  <= '0;
      S_DEVW: ms_r  <= ONE_Q16 - 17'(div_quo[15:0]);
      S_VAR1: begin
        vs_r <= '0;
        for (int k = 0; k < 3; k++) begin
          a_r[k] <= AW'(fill_r) * AW'(sxx_r[k]);
          b_r[k] <= bsq[k];
        end
        nn_r <= (2*CW)'(fill_r) * (2*CW)'(fill_r);
      end
      S_VAR2: begin
        num_r <= num_sum;
        den_r <= DENW'(nn_r) * DENW'(var_limit_r);
      end
      S_VARW: vs_r <= ONE_Q16 - 17'(div_quo[15:0]);
      S_MIX:  begin
        // The range score reuses r_r as its operand slot until the sum lands.
        r_r <= 17'(mix_sum[33:16]);
      end
      S_SMO1: begin
        p1_r <= 32'(smooth_r) * 32'(smooth_w_r);
        p2_r <= 34'(r_r) * 34'(ONE_Q16 - 17'(smooth_w_r));
      end
      S_SMO2: rel_r <= (smo_q > 18'd65535) ? 16'hFFFF : smo_q[15:0];
      default: begin
      end
    endcase
    // Range score is loaded just before the weighted sum.
    if (state_r == S_VAR3 || state_r == S_VARW) begin
      if (state_nxt == S_MIX) begin
        r_r <= in_range ? ONE_Q16 : 17'd0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_valid_r || out_ch.ready)) begin
      out_ch.reliability    <= rel_r;
      out_ch.calibrated     <= cal_done_r;
      out_ch.history_fill   <= 5'(fill_r);
      out_ch.expected_level <= exp_mag_r;
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;

endmodule
`default_nettype wire

### rtl/mrs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scorer port checker
// Watches the top-level ports of the scorer over time.
// ----------------------------------------------------------------------------
module mrs_port_checker #(
  parameter int RING_DEPTH = 16
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] reliability,
  input wire logic        calibrated,
  input wire logic [4:0]  history_fill
);

  // A stalled result keeps its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(reliability))
    else $error("result changed while stalled");

  // One item at a time: a transfer closes the input until the item is done.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  // Fewer than three samples always scores zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (RING_DEPTH < 32) && (history_fill < 5'd3) |-> reliability == 16'd0)
    else $error("non-zero reliability under three samples");

  // Calibration needs at least three held samples.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (RING_DEPTH < 32) && calibrated |-> history_fill >= 5'd3)
    else $error("calibrated with fewer than three samples");

  // No result comes out of reset.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind magnetometer_reliability_scorer mrs_port_checker #(.RING_DEPTH(RING_DEPTH)) u_mrs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .reliability  (out_ch.reliability),
  .calibrated   (out_ch.calibrated),
  .history_fill (out_ch.history_fill)
);
`default_nettype wire
